// File: rtl/mmap_pkg.sv
// Package for the paired matrix multiply-add unit: sizes, widths, request kinds
// and the control word handed to the multiply-accumulate lanes. No dependencies.
package mmap_pkg;

   localparam int DIM     = 8;
   localparam int VAC     = 4;
   localparam int A_COLS  = DIM + VAC;
   localparam int A_ROWS  = 2 * DIM;
   localparam int A_DEPTH = A_ROWS * A_COLS;
   localparam int X_DEPTH = DIM * VAC;

   // Accumulator holds DIM products plus the offset term exactly.
   localparam int ACC_W = 64 + $clog2(DIM + 1);

   // request kinds carried on tuser; the spare kind is dropped
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_X = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctrl_type;

endpackage

// File: rtl/mmap_mac.sv
// Multiply-accumulate lane: registered 32x32 signed product, exact wide
// accumulator, shift right 16 and saturate to 32 bits. Uses mmap_pkg.
module mmap_mac import mmap_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  mac_ctrl_type       ctrl,
   input  logic signed [31:0] a_op,
   input  logic signed [31:0] x_op,
   output logic signed [31:0] result
);

   mac_ctrl_type              ctrl_ff;
   logic signed [63:0]        prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic [ACC_W-48:0]         upper;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (adv) begin
         ctrl_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= a_op * x_op;
      end
      if (adv && ctrl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      acc_in = ctrl_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      upper  = acc_in[ACC_W-1:47];
      // keep floor(acc / 2^16) when it fits in 32 bits, else clamp
      if ((&upper) || !(|upper)) begin
         result = acc_in[47:16];
      end else if (acc_in[ACC_W-1]) begin
         result = 32'sh8000_0000;
      end else begin
         result = 32'sh7fff_ffff;
      end
   end

endmodule

// File: rtl/matrix_multiply_add_pair_unit.sv
// Paired matrix multiply-add, Q16.16: A and X stores, read sequencer and two
// multiply-accumulate lanes. Uses mmap_pkg and mmap_mac.
//
//   channel  direction  tuser     tlast  tdata (low bit up)
//   req      in         kind      -      row[3:0] col[7:4] value[39:8]
//   rsp      out        -         last   out_row out_col top_sum bottom_sum
//
// A start runs DIM*VAC results, each an offset read then DIM product steps
// (one A pair and one X element per cycle while the output is not stalled),
// through the read, product and output registers. The A store's two read
// ports set that rate. New requests wait until the last result is in the output
// register. A stalled output freezes the whole read and multiply pipeline.
// Reset clears control only; store contents are undefined until loaded.
module matrix_multiply_add_pair_unit import mmap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [39:0] req_tdata,   // row[3:0], col[7:4], value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // last
   output logic [71:0] rsp_tdata    // out_row[2:0], out_col[4:3], top_sum[36:5],
                                    // bottom_sum[68:37], zero pad[71:69]
);

   localparam int KW  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int JW  = (VAC > 1) ? $clog2(VAC) : 1;
   localparam int TW  = $clog2(DIM + 1);
   localparam int RW  = $clog2(A_ROWS);
   localparam int CW  = (A_COLS > 1) ? $clog2(A_COLS) : 1;
   localparam int AAW = $clog2(A_DEPTH);
   localparam int XAW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;

   typedef struct packed {
      logic          valid;
      logic          first;
      logic          last_term;
      logic          final_run;
      logic [KW-1:0] k;
      logic [JW-1:0] j;
   } tag_type;

   logic [31:0] a_mem [A_DEPTH];
   logic [31:0] x_mem [X_DEPTH];

   logic          busy_ff;
   logic          issuing_ff;
   logic [TW-1:0] t_ff;
   logic [KW-1:0] k_ff;
   logic [JW-1:0] j_ff;
   tag_type       issue_tag;
   tag_type       s1_ff;
   tag_type       s2_ff;

   logic signed [31:0] rd_top_ff;
   logic signed [31:0] rd_bot_ff;
   logic signed [31:0] rd_x_ff;
   logic signed [31:0] x_op;
   logic signed [31:0] top_res;
   logic signed [31:0] bot_res;
   mac_ctrl_type       mac_ctrl;

   logic          rsp_valid_ff;
   logic [2:0]    out_row_ff;
   logic [1:0]    out_col_ff;
   logic [31:0]   top_ff;
   logic [31:0]   bot_ff;
   logic          last_ff;

   logic          adv;
   logic          req_fire;
   logic [3:0]    req_row;
   logic [3:0]    req_col;
   logic [31:0]   req_value;
   logic [AAW-1:0] load_a_addr;
   logic [XAW-1:0] load_x_addr;
   logic [RW-1:0]  row_top;
   logic [RW-1:0]  row_bot;
   logic [CW-1:0]  a_col;
   logic [KW-1:0]  x_row;
   logic [AAW-1:0] rd_top_addr;
   logic [AAW-1:0] rd_bot_addr;
   logic [XAW-1:0] rd_x_addr;
   logic           load_out;

   assign adv       = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy_ff;
   assign req_fire  = req_tvalid && req_tready;
   assign req_row   = req_tdata[3:0];
   assign req_col   = req_tdata[7:4];
   assign req_value = req_tdata[39:8];

   assign load_a_addr = AAW'(req_row) * AAW'(A_COLS) + AAW'(req_col);
   assign load_x_addr = XAW'(req_row) * XAW'(VAC) + XAW'(req_col);

   // step zero reads the offset column, steps 1..DIM the product terms
   always_comb begin
      row_top = RW'(k_ff);
      row_bot = RW'(k_ff) + RW'(DIM);
      if (t_ff == '0) begin
         a_col = CW'(DIM) + CW'(j_ff);
         x_row = '0;
      end else begin
         a_col = CW'(t_ff - 1'b1);
         x_row = KW'(t_ff - 1'b1);
      end
      rd_top_addr = AAW'(row_top) * AAW'(A_COLS) + AAW'(a_col);
      rd_bot_addr = AAW'(row_bot) * AAW'(A_COLS) + AAW'(a_col);
      rd_x_addr   = XAW'(x_row) * XAW'(VAC) + XAW'(j_ff);

      issue_tag.valid     = issuing_ff;
      issue_tag.first     = (t_ff == '0);
      issue_tag.last_term = (t_ff == TW'(DIM));
      issue_tag.final_run = (t_ff == TW'(DIM)) && (k_ff == KW'(DIM - 1))
                            && (j_ff == JW'(VAC - 1));
      issue_tag.k         = k_ff;
      issue_tag.j         = j_ff;
   end

   // stores: one write port for loads, registered reads for the sequencer
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == KIND_LOAD_A && req_row < A_ROWS && req_col < A_COLS) begin
         a_mem[load_a_addr] <= req_value;
      end
      if (adv) begin
         rd_top_ff <= a_mem[rd_top_addr];
         rd_bot_ff <= a_mem[rd_bot_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == KIND_LOAD_X && req_row < DIM && req_col < VAC) begin
         x_mem[load_x_addr] <= req_value;
      end
      if (adv) begin
         rd_x_ff <= x_mem[rd_x_addr];
      end
   end

   // sequencer: t inner, k middle, j outer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         issuing_ff <= 1'b0;
         t_ff       <= '0;
         k_ff       <= '0;
         j_ff       <= '0;
      end else begin
         if (req_fire && req_tuser == KIND_START) begin
            busy_ff    <= 1'b1;
            issuing_ff <= 1'b1;
            t_ff       <= '0;
            k_ff       <= '0;
            j_ff       <= '0;
         end else if (adv && issuing_ff) begin
            if (t_ff == TW'(DIM)) begin
               t_ff <= '0;
               if (k_ff == KW'(DIM - 1)) begin
                  k_ff <= '0;
                  if (j_ff == JW'(VAC - 1)) begin
                     j_ff       <= '0;
                     issuing_ff <= 1'b0;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end else begin
               t_ff <= t_ff + 1'b1;
            end
         end
         if (load_out && s2_ff.final_run) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (adv) begin
         s1_ff <= issue_tag;
         s2_ff <= s1_ff;
      end
   end

   // offset term goes through the multiplier scaled by one in Q16.16
   assign x_op           = s1_ff.first ? 32'sh0001_0000 : rd_x_ff;
   assign mac_ctrl.valid = s1_ff.valid;
   assign mac_ctrl.first = s1_ff.first;

   mmap_mac u_top_mac (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctrl   (mac_ctrl),
      .a_op   (rd_top_ff),
      .x_op   (x_op),
      .result (top_res)
   );

   mmap_mac u_bot_mac (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .ctrl   (mac_ctrl),
      .a_op   (rd_bot_ff),
      .x_op   (x_op),
      .result (bot_res)
   );

   assign load_out = adv && s2_ff.valid && s2_ff.last_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_ff.valid && s2_ff.last_term;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_row_ff <= 3'(s2_ff.k);
         out_col_ff <= 2'(s2_ff.j);
         top_ff     <= top_res;
         bot_ff     <= bot_res;
         last_ff    <= s2_ff.final_run;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {3'b000, bot_ff, top_ff, out_col_ff, out_row_ff};

   a_inflight_busy: assert property (@(posedge clock) disable iff (reset)
      (issuing_ff || s1_ff.valid || s2_ff.valid) |-> busy_ff)
      else $error("work in flight while unit reports idle");

   a_final_frees: assert property (@(posedge clock) disable iff (reset)
      (load_out && s2_ff.final_run) |=> (!busy_ff && !issuing_ff))
      else $error("unit still busy after final result");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tdata[2:0] == 3'(DIM - 1) && rsp_tdata[4:3] == 2'(VAC - 1)))
      else $error("last flag on a result other than the final one");

endmodule

// File: tb/sv/matrix_multiply_add_pair_unit_tb.sv
// Self-checking bench for matrix_multiply_add_pair_unit: loads A and X, starts runs,
// and checks every result pair against an in-bench Q16.16 predictor.
// Depends on mmap_pkg and the unit's RTL only.
module matrix_multiply_add_pair_unit_tb import mmap_pkg::*; ();

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 170;
   localparam int TAIL_ITEMS   = 30;
   localparam int DRAIN_CYCLES = 320;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q16_MIN = 32'h8000_0000;
   localparam logic signed [127:0] SUM_MAX = 128'sd2147483647;
   localparam logic signed [127:0] SUM_MIN = -128'sd2147483648;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [31:0] value;
   } request_type;

   typedef struct packed {
      logic [2:0]  out_row;
      logic [1:0]  out_col;
      logic [31:0] top_sum;
      logic [31:0] bottom_sum;
      logic        last;
   } sum_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;   // kind
   logic [39:0] req_tdata = '0;   // row[3:0], col[7:4], value[39:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tlast;       // last
   logic [71:0] rsp_tdata;       // out_row[2:0], out_col[4:3], top_sum[36:5],
                                 // bottom_sum[68:37], zero pad[71:69]

   matrix_multiply_add_pair_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   request_type  pending_requests[$];
   sum_pair_type expected_pairs[$];
   request_type  next_request;
   sum_pair_type want_pair;

   // Predictor copy of the operand stores.
   logic signed [31:0] a_mem [A_ROWS][A_COLS];
   logic signed [31:0] x_mem [DIM][VAC];

   logic req_fire = 1'b0;
   logic req_bursty = 1'b0;
   logic rsp_bursty = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   int   mode_left = 0;

   int unsigned mismatches = 0;
   int unsigned requests_taken = 0;
   int unsigned starts_taken = 0;
   int unsigned loads_ignored = 0;
   int unsigned pairs_checked = 0;
   int unsigned saturated_sums = 0;
   int unsigned timeout_cycles;

   function automatic logic [31:0] pick_value(bit allow_wide);
      int unsigned sel;
      int unsigned span;
      int unsigned mag;
      sel = $urandom_range(0, 99);
      if (allow_wide && sel < 7)
         return $urandom();
      if (allow_wide && sel < 12) begin
         case ($urandom_range(0, 4))
            0: return Q16_MAX;
            1: return Q16_MIN;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            default: return 32'd1;
         endcase
      end
      span = 32'd1 << $urandom_range(4, 20);
      mag = $urandom_range(0, span - 1);
      return ($urandom_range(0, 1) != 0) ? -mag : mag;
   endfunction

   task automatic queue_request(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
                                logic [31:0] value);
      request_type r;
      r.kind = kind;
      r.row = row;
      r.col = col;
      r.value = value;
      pending_requests.push_back(r);
   endtask

   // Offset column scaled to Q32.32 plus exact products, floor shift, saturate.
   function automatic logic [31:0] q16_row_dot(int arow, int j);
      logic signed [127:0] acc;
      logic signed [63:0]  prod;
      acc = a_mem[arow][DIM + j];
      acc = acc <<< 16;
      for (int i = 0; i < DIM; i++) begin
         prod = a_mem[arow][i] * x_mem[i][j];
         acc += prod;
      end
      acc = acc >>> 16;
      if (acc > SUM_MAX) begin
         saturated_sums++;
         return Q16_MAX;
      end
      if (acc < SUM_MIN) begin
         saturated_sums++;
         return Q16_MIN;
      end
      return acc[31:0];
   endfunction

   task automatic apply_request(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
                                logic [31:0] value);
      sum_pair_type p;
      requests_taken++;
      case (kind)
         KIND_LOAD_A: begin
            if (row < A_ROWS && col < A_COLS)
               a_mem[row][col] = value;
            else
               loads_ignored++;
         end
         KIND_LOAD_X: begin
            if (row < DIM && col < VAC)
               x_mem[row][col] = value;
            else
               loads_ignored++;
         end
         KIND_START: begin
            starts_taken++;
            for (int j = 0; j < VAC; j++) begin
               for (int k = 0; k < DIM; k++) begin
                  p.out_row = 3'(k);
                  p.out_col = 2'(j);
                  p.top_sum = q16_row_dot(k, j);
                  p.bottom_sum = q16_row_dot(DIM + k, j);
                  p.last = (j == VAC - 1 && k == DIM - 1);
                  expected_pairs.push_back(p);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch on result %0d, %s: expected %h, got %h",
                  pairs_checked, field, want, got);
   endtask

   // Sample both channels at the rising edge: results first, then requests.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pairs.size() == 0) begin
            flag_mismatch("unexpected result, top_sum", 32'd0, rsp_tdata[36:5]);
         end else begin
            want_pair = expected_pairs.pop_front();
            if (rsp_tdata[2:0] !== want_pair.out_row)
               flag_mismatch("out_row", 32'(want_pair.out_row), 32'(rsp_tdata[2:0]));
            if (rsp_tdata[4:3] !== want_pair.out_col)
               flag_mismatch("out_col", 32'(want_pair.out_col), 32'(rsp_tdata[4:3]));
            if (rsp_tdata[36:5] !== want_pair.top_sum)
               flag_mismatch("top_sum", want_pair.top_sum, rsp_tdata[36:5]);
            if (rsp_tdata[68:37] !== want_pair.bottom_sum)
               flag_mismatch("bottom_sum", want_pair.bottom_sum, rsp_tdata[68:37]);
            if (rsp_tlast !== want_pair.last)
               flag_mismatch("last", 32'(want_pair.last), 32'(rsp_tlast));
         end
         pairs_checked++;
      end
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         apply_request(req_tuser, req_tdata[3:0], req_tdata[7:4], req_tdata[39:8]);
   end

   // Switch between bursty and steady stretches on each side.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left <= $urandom_range(50, 400);
         req_bursty <= ($urandom_range(0, 2) != 0);
         rsp_bursty <= ($urandom_range(0, 2) != 0);
      end else begin
         mode_left <= mode_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (req_tvalid && req_bursty && pending_requests.size() > TAIL_ITEMS &&
                      $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(0, 13);
            req_tvalid <= 1'b0;
         end else begin
            next_request = pending_requests.pop_front();
            req_tuser <= next_request.kind;
            req_tdata <= {next_request.value, next_request.col, next_request.row};
            req_tvalid <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_bursty && pending_requests.size() > TAIL_ITEMS &&
                   $urandom_range(0, 7) == 0) begin
         rsp_stall <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++)
         @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int unsigned random_items;
      int unsigned round_len;
      int unsigned sel;

      // Write every element before the first start so no run reads stale storage.
      for (int r = 0; r < A_ROWS; r++)
         for (int c = 0; c < A_COLS; c++)
            queue_request(KIND_LOAD_A, 4'(r), 4'(c), pick_value(1'b0));
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < VAC; c++)
            queue_request(KIND_LOAD_X, 4'(r), 4'(c), pick_value(1'b0));

      // Saturation both ways, offset extremes, corner indexes, ignored requests.
      queue_request(KIND_LOAD_A, 4'd0, 4'd0, Q16_MAX);
      queue_request(KIND_LOAD_X, 4'd0, 4'd0, Q16_MAX);
      queue_request(KIND_LOAD_A, 4'd8, 4'd0, Q16_MIN);
      queue_request(KIND_LOAD_A, 4'd2, 4'd1, Q16_MIN);
      queue_request(KIND_LOAD_X, 4'd1, 4'd1, Q16_MIN);
      queue_request(KIND_LOAD_A, 4'd1, 4'd8, Q16_MIN);
      queue_request(KIND_LOAD_A, 4'd9, 4'd9, Q16_MAX);
      queue_request(KIND_LOAD_A, 4'd15, 4'd11, Q16_MAX);
      queue_request(KIND_LOAD_X, 4'd7, 4'd3, 32'hFFFF_FFFF);
      queue_request(KIND_LOAD_A, 4'd3, 4'd4, 32'd0);
      queue_request(KIND_LOAD_X, 4'd4, 4'd2, 32'd1);
      queue_request(KIND_LOAD_A, 4'd15, 4'd12, Q16_MIN);
      queue_request(KIND_LOAD_A, 4'd0, 4'd15, Q16_MAX);
      queue_request(KIND_LOAD_X, 4'd8, 4'd0, Q16_MAX);
      queue_request(KIND_LOAD_X, 4'd7, 4'd4, Q16_MIN);
      queue_request(KIND_LOAD_X, 4'd15, 4'd15, 32'hFFFF_FFFF);
      queue_request(KIND_SPARE, 4'd15, 4'd15, Q16_MAX);
      queue_request(KIND_SPARE, 4'd0, 4'd0, 32'd0);
      queue_request(KIND_START, 4'd15, 4'd15, 32'hFFFF_FFFF);
      queue_request(KIND_START, 4'd0, 4'd0, 32'd0);

      // Rounds of reloads with some noise, each closed by a start.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         round_len = $urandom_range(6, 24);
         repeat (round_len) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
               queue_request(KIND_LOAD_A, 4'($urandom_range(0, A_ROWS - 1)),
                             4'($urandom_range(0, A_COLS - 1)), pick_value(1'b1));
               random_items++;
            end else if (sel < 80) begin
               queue_request(KIND_LOAD_X, 4'($urandom_range(0, DIM - 1)),
                             4'($urandom_range(0, VAC - 1)), pick_value(1'b1));
               random_items++;
            end else if (sel < 87) begin
               queue_request(KIND_LOAD_A, 4'($urandom_range(0, 15)),
                             4'($urandom_range(A_COLS, 15)), $urandom());
            end else if (sel < 93) begin
               if ($urandom_range(0, 1) != 0)
                  queue_request(KIND_LOAD_X, 4'($urandom_range(DIM, 15)),
                                4'($urandom_range(0, 15)), $urandom());
               else
                  queue_request(KIND_LOAD_X, 4'($urandom_range(0, 15)),
                                4'($urandom_range(VAC, 15)), $urandom());
            end else begin
               queue_request(KIND_SPARE, 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), $urandom());
            end
         end
         queue_request(KIND_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       $urandom());
         random_items++;
         // Repeat the start now and then with nothing reloaded in between.
         if ($urandom_range(0, 5) == 0) begin
            queue_request(KIND_START, 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), $urandom());
            random_items++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d starts, %0d out-of-range loads ignored",
               requests_taken, starts_taken, loads_ignored);
      $display("checked %0d result pairs, %0d sums saturated, %0d mismatches",
               pairs_checked, saturated_sums, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/mmap_pkg.sv
rtl/mmap_mac.sv
rtl/matrix_multiply_add_pair_unit.sv
tb/sv/matrix_multiply_add_pair_unit_tb.sv
